// ----- rtl/spdu_pkg.sv -----
// shared types, codes and defaults of the modbus slave pdu engine
`default_nettype none
package spdu_pkg;

	// default table and buffer sizes
	localparam int COIL_DEPTH_DEF     = 1024;
	localparam int DISCRETE_DEPTH_DEF = 1024;
	localparam int HOLDING_DEPTH_DEF  = 256;
	localparam int INREG_DEPTH_DEF    = 256;
	localparam int REQ_DEPTH_DEF      = 256;

	// largest response in bytes
	localparam int MAX_RESP_BYTES = 64;

	// request buffer pointer width, covers header plus 255 data bytes
	localparam int BPTR_W = 9;
	localparam int HDR_BYTES = 6;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_COIL_BASE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COIL_COUNT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCRETE_BASE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCRETE_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLDING_BASE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLDING_COUNT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_INREG_BASE     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_INREG_COUNT    = 3'd7;

	// input actions
	localparam logic [1:0] ACT_REQ   = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// table selects
	localparam logic [1:0] TBL_COIL     = 2'd0;
	localparam logic [1:0] TBL_DISCRETE = 2'd1;
	localparam logic [1:0] TBL_HOLDING  = 2'd2;
	localparam logic [1:0] TBL_INREG    = 2'd3;

	// function codes
	localparam logic [7:0] FC_READ_COILS    = 8'd1;
	localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
	localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
	localparam logic [7:0] FC_READ_INREGS   = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
	localparam logic [7:0] FC_WRITE_REG     = 8'd6;
	localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

	localparam logic [7:0]  EXC_FLAG = 8'h80;
	localparam logic [15:0] COIL_ON  = 16'hFF00;

	// exception codes
	typedef enum logic [1:0] {
		EXC_NONE  = 2'd0,
		EXC_FUNC  = 2'd1,
		EXC_ADDR  = 2'd2,
		EXC_VALUE = 2'd3
	} exc_t;

	// configuration registers
	typedef struct packed {
		logic [15:0] coil_base;
		logic [10:0] coil_count;
		logic [15:0] discrete_base;
		logic [10:0] discrete_count;
		logic [15:0] holding_base;
		logic [8:0]  holding_count;
		logic [15:0] inreg_base;
		logic [8:0]  inreg_count;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic        out_kind;
		logic [7:0]  resp_byte;
		logic        resp_last;
		logic [15:0] read_value;
	} out_item_t;

endpackage
`default_nettype wire

// ----- rtl/spdu_ram.sv -----
// generic single write port, single read port ram with registered read
`default_nettype none
module spdu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/spdu_engine.sv -----
// request sequencer with the request buffer and the four table memories
`default_nettype none
module spdu_engine #(
	parameter int COIL_DEPTH     = spdu_pkg::COIL_DEPTH_DEF,
	parameter int DISCRETE_DEPTH = spdu_pkg::DISCRETE_DEPTH_DEF,
	parameter int HOLDING_DEPTH  = spdu_pkg::HOLDING_DEPTH_DEF,
	parameter int INREG_DEPTH    = spdu_pkg::INREG_DEPTH_DEF,
	parameter int REQ_DEPTH      = spdu_pkg::REQ_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         action,
	input  wire logic [7:0]         pdu_byte,
	input  wire logic               pdu_last,
	input  wire logic [1:0]         table_sel,
	input  wire logic [9:0]         local_index,
	input  wire logic [15:0]        local_data,
	input  wire spdu_pkg::cfg_t     cfg,
	input  wire logic               out_free,
	output logic                    out_load,
	output spdu_pkg::out_item_t     out_item
);

	localparam int CAW = (COIL_DEPTH > 1) ? $clog2(COIL_DEPTH) : 1;
	localparam int DAW = (DISCRETE_DEPTH > 1) ? $clog2(DISCRETE_DEPTH) : 1;
	localparam int HAW = (HOLDING_DEPTH > 1) ? $clog2(HOLDING_DEPTH) : 1;
	localparam int IAW = (INREG_DEPTH > 1) ? $clog2(INREG_DEPTH) : 1;
	localparam int RAW = $clog2(REQ_DEPTH);
	localparam int LEN_W = $clog2(REQ_DEPTH + 1);
	localparam int MAX_CD = (COIL_DEPTH > DISCRETE_DEPTH) ? COIL_DEPTH : DISCRETE_DEPTH;
	localparam int MAX_RD = (HOLDING_DEPTH > INREG_DEPTH) ? HOLDING_DEPTH : INREG_DEPTH;
	localparam int MAX_DEPTH = (MAX_CD > MAX_RD) ? MAX_CD : MAX_RD;
	localparam int CLR_W = $clog2(MAX_DEPTH) + 1;
	localparam int HDR_BYTES_L = spdu_pkg::HDR_BYTES;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_LRD, S_CHK, S_EXC, S_ECHO, S_RHDR,
		S_RB_ISSUE, S_RB_TAKE, S_RB_EMIT,
		S_RW_ISSUE, S_RW_TAKE, S_RW_HI, S_RW_LO,
		S_WB_ISSUE, S_WB_TAKE, S_WB_BIT,
		S_WW_ISSUE, S_WW_HI, S_WW_LO
	} state_t;

	state_t              state_q;
	logic [CLR_W-1:0]    clr_q;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    rlen_q;
	logic [7:0]          hdr_q [HDR_BYTES_L];
	logic [7:0]          fc_q;
	logic [15:0]         addr_q;
	logic [15:0]         val_q;
	spdu_pkg::exc_t      code_q;
	logic [7:0]          nbytes_q;
	logic [16:0]         ptr_q;
	logic [16:0]         elem_q;
	logic [16:0]         cnt_q;
	logic [2:0]          k_q;
	logic [7:0]          acc_q;
	logic [7:0]          byte_q;
	logic [7:0]          hi_q;
	logic [15:0]         word_q;
	logic                ok_q;
	logic [2:0]          ph_q;
	logic [spdu_pkg::BPTR_W-1:0] bptr_q;
	logic [1:0]          lsel_q;
	logic                lok_q;

	logic                acc;
	logic                tbl_re;
	logic                buf_we;
	logic                buf_re;
	logic [7:0]          buf_rd;
	logic                coil_we, disc_we, hold_we, inreg_we;
	logic [CAW-1:0]      coil_wa;
	logic [DAW-1:0]      disc_wa;
	logic [HAW-1:0]      hold_wa;
	logic [IAW-1:0]      inreg_wa;
	logic                coil_wd, disc_wd;
	logic [15:0]         hold_wd, inreg_wd;
	logic                coil_rd, disc_rd;
	logic [15:0]         hold_rd, inreg_rd;
	logic [16:0]         lidx;
	logic                lidx_ok;

	// header fields seen through the received length
	logic [7:0]          h_fc, h5;
	logic [15:0]         h_addr, h_val;
	logic [16:0]         tbase, tcnt, addr17, val17, diff, room, nb_bits, nb_words;
	logic                in_rng, qbad;
	spdu_pkg::exc_t      code;
	logic                is_bits;
	logic                buf_data_ok;
	logic [7:0]          buf_byte;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;
	assign lidx     = {7'd0, local_index};

	// local index range check per table
	always_comb begin
		case (table_sel)
			spdu_pkg::TBL_COIL:     lidx_ok = lidx < 17'(COIL_DEPTH);
			spdu_pkg::TBL_DISCRETE: lidx_ok = lidx < 17'(DISCRETE_DEPTH);
			spdu_pkg::TBL_HOLDING:  lidx_ok = lidx < 17'(HOLDING_DEPTH);
			default:                lidx_ok = lidx < 17'(INREG_DEPTH);
		endcase
	end

	// header decode
	assign h_fc   = (len_q > LEN_W'(0)) ? hdr_q[0] : 8'd0;
	assign h_addr = {(len_q > LEN_W'(1)) ? hdr_q[1] : 8'd0,
	                 (len_q > LEN_W'(2)) ? hdr_q[2] : 8'd0};
	assign h_val  = {(len_q > LEN_W'(3)) ? hdr_q[3] : 8'd0,
	                 (len_q > LEN_W'(4)) ? hdr_q[4] : 8'd0};
	assign h5     = (len_q > LEN_W'(5)) ? hdr_q[5] : 8'd0;

	// table base and capped count for the function code
	always_comb begin
		case (h_fc)
			spdu_pkg::FC_READ_COILS, spdu_pkg::FC_WRITE_COIL,
			spdu_pkg::FC_WRITE_COILS: begin
				tbase = {1'b0, cfg.coil_base};
				tcnt  = (17'(cfg.coil_count) < 17'(COIL_DEPTH)) ?
				        17'(cfg.coil_count) : 17'(COIL_DEPTH);
			end
			spdu_pkg::FC_READ_DISCRETE: begin
				tbase = {1'b0, cfg.discrete_base};
				tcnt  = (17'(cfg.discrete_count) < 17'(DISCRETE_DEPTH)) ?
				        17'(cfg.discrete_count) : 17'(DISCRETE_DEPTH);
			end
			spdu_pkg::FC_READ_INREGS: begin
				tbase = {1'b0, cfg.inreg_base};
				tcnt  = (17'(cfg.inreg_count) < 17'(INREG_DEPTH)) ?
				        17'(cfg.inreg_count) : 17'(INREG_DEPTH);
			end
			default: begin
				tbase = {1'b0, cfg.holding_base};
				tcnt  = (17'(cfg.holding_count) < 17'(HOLDING_DEPTH)) ?
				        17'(cfg.holding_count) : 17'(HOLDING_DEPTH);
			end
		endcase
	end

	assign addr17   = {1'b0, h_addr};
	assign val17    = {1'b0, h_val};
	assign in_rng   = (addr17 >= tbase) && (addr17 < tbase + tcnt);
	assign diff     = addr17 - tbase;
	assign room     = tcnt - diff;
	assign qbad     = (h_val == 16'd0) || (val17 > room);
	assign nb_bits  = (val17 + 17'd7) >> 3;
	assign nb_words = val17 << 1;
	assign is_bits  = (h_fc == spdu_pkg::FC_READ_COILS) ||
	                  (h_fc == spdu_pkg::FC_READ_DISCRETE);

	// request check
	always_comb begin
		code = spdu_pkg::EXC_NONE;
		case (h_fc)
			spdu_pkg::FC_READ_COILS, spdu_pkg::FC_READ_DISCRETE: begin
				if (!in_rng) begin
					code = spdu_pkg::EXC_ADDR;
				end else if (qbad ||
				             (18'(nb_bits) + 18'd2 > 18'(spdu_pkg::MAX_RESP_BYTES))) begin
					code = spdu_pkg::EXC_VALUE;
				end
			end
			spdu_pkg::FC_READ_HOLDING, spdu_pkg::FC_READ_INREGS: begin
				if (!in_rng) begin
					code = spdu_pkg::EXC_ADDR;
				end else if (qbad ||
				             (18'(nb_words) + 18'd2 > 18'(spdu_pkg::MAX_RESP_BYTES))) begin
					code = spdu_pkg::EXC_VALUE;
				end
			end
			spdu_pkg::FC_WRITE_COIL: begin
				if (!in_rng) begin
					code = spdu_pkg::EXC_ADDR;
				end else if ((h_val != spdu_pkg::COIL_ON) && (h_val != 16'd0)) begin
					code = spdu_pkg::EXC_VALUE;
				end
			end
			spdu_pkg::FC_WRITE_REG: begin
				if (!in_rng) begin
					code = spdu_pkg::EXC_ADDR;
				end
			end
			spdu_pkg::FC_WRITE_COILS: begin
				if (!in_rng) begin
					code = spdu_pkg::EXC_ADDR;
				end else if (qbad || (nb_bits != {9'd0, h5})) begin
					code = spdu_pkg::EXC_VALUE;
				end
			end
			spdu_pkg::FC_WRITE_REGS: begin
				if (!in_rng) begin
					code = spdu_pkg::EXC_ADDR;
				end else if (qbad || (nb_words != {9'd0, h5})) begin
					code = spdu_pkg::EXC_VALUE;
				end
			end
			default: code = spdu_pkg::EXC_FUNC;
		endcase
	end

	// request buffer ports
	assign buf_we      = acc && (action == spdu_pkg::ACT_REQ) &&
	                     (len_q < LEN_W'(REQ_DEPTH));
	assign buf_re      = (state_q == S_WB_ISSUE) || (state_q == S_WW_ISSUE) ||
	                     (state_q == S_WW_HI);
	assign buf_data_ok = bptr_q < spdu_pkg::BPTR_W'(rlen_q);
	assign buf_byte    = ok_q ? buf_rd : 8'd0;

	// table reads share one address
	assign tbl_re = (acc && (action == spdu_pkg::ACT_READ)) ||
	                (state_q == S_RB_ISSUE) || (state_q == S_RW_ISSUE);

	// table write port selection
	always_comb begin
		coil_we  = 1'b0;
		disc_we  = 1'b0;
		hold_we  = 1'b0;
		inreg_we = 1'b0;
		coil_wa  = CAW'(ptr_q);
		disc_wa  = DAW'(lidx);
		hold_wa  = HAW'(ptr_q);
		inreg_wa = IAW'(lidx);
		coil_wd  = 1'b0;
		disc_wd  = 1'b0;
		hold_wd  = 16'd0;
		inreg_wd = 16'd0;
		case (state_q)
			S_CLR: begin
				coil_we  = 32'(clr_q) < 32'(COIL_DEPTH);
				disc_we  = 32'(clr_q) < 32'(DISCRETE_DEPTH);
				hold_we  = 32'(clr_q) < 32'(HOLDING_DEPTH);
				inreg_we = 32'(clr_q) < 32'(INREG_DEPTH);
				coil_wa  = CAW'(clr_q);
				disc_wa  = DAW'(clr_q);
				hold_wa  = HAW'(clr_q);
				inreg_wa = IAW'(clr_q);
			end
			S_IDLE: begin
				coil_wa  = CAW'(lidx);
				hold_wa  = HAW'(lidx);
				coil_wd  = local_data[0];
				disc_wd  = local_data[0];
				hold_wd  = local_data;
				inreg_wd = local_data;
				if (acc && (action == spdu_pkg::ACT_WRITE) && lidx_ok) begin
					coil_we  = (table_sel == spdu_pkg::TBL_COIL);
					disc_we  = (table_sel == spdu_pkg::TBL_DISCRETE);
					hold_we  = (table_sel == spdu_pkg::TBL_HOLDING);
					inreg_we = (table_sel == spdu_pkg::TBL_INREG);
				end
			end
			S_CHK: begin
				coil_wa = CAW'(diff);
				hold_wa = HAW'(diff);
				coil_wd = (h_val != 16'd0);
				hold_wd = h_val;
				coil_we = (code == spdu_pkg::EXC_NONE) && (h_fc == spdu_pkg::FC_WRITE_COIL);
				hold_we = (code == spdu_pkg::EXC_NONE) && (h_fc == spdu_pkg::FC_WRITE_REG);
			end
			S_WB_BIT: begin
				coil_we = 1'b1;
				coil_wd = byte_q[k_q];
			end
			S_WW_LO: begin
				hold_we = 1'b1;
				hold_wd = {hi_q, buf_byte};
			end
			default: ;
		endcase
	end

	// result item of the current state
	always_comb begin
		out_load = 1'b0;
		out_item = '0;
		case (state_q)
			S_LRD: begin
				out_load = out_free;
				out_item.out_kind = 1'b1;
				if (lok_q) begin
					case (lsel_q)
						spdu_pkg::TBL_COIL:     out_item.read_value = {15'd0, coil_rd};
						spdu_pkg::TBL_DISCRETE: out_item.read_value = {15'd0, disc_rd};
						spdu_pkg::TBL_HOLDING:  out_item.read_value = hold_rd;
						default:                out_item.read_value = inreg_rd;
					endcase
				end
			end
			S_EXC: begin
				out_load = out_free;
				out_item.resp_byte = (ph_q == 3'd0) ? (fc_q | spdu_pkg::EXC_FLAG) :
				                     {6'd0, code_q};
				out_item.resp_last = (ph_q == 3'd1);
			end
			S_ECHO: begin
				out_load = out_free;
				case (ph_q)
					3'd0:    out_item.resp_byte = fc_q;
					3'd1:    out_item.resp_byte = addr_q[15:8];
					3'd2:    out_item.resp_byte = addr_q[7:0];
					3'd3:    out_item.resp_byte = val_q[15:8];
					default: out_item.resp_byte = val_q[7:0];
				endcase
				out_item.resp_last = (ph_q == 3'd4);
			end
			S_RHDR: begin
				out_load = out_free;
				out_item.resp_byte = (ph_q == 3'd0) ? fc_q : nbytes_q;
			end
			S_RB_EMIT: begin
				out_load = out_free;
				out_item.resp_byte = acc_q;
				out_item.resp_last = (cnt_q == 17'd1);
			end
			S_RW_HI: begin
				out_load = out_free;
				out_item.resp_byte = word_q[15:8];
			end
			S_RW_LO: begin
				out_load = out_free;
				out_item.resp_byte = word_q[7:0];
				out_item.resp_last = (cnt_q == 17'd1);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			len_q    <= '0;
			rlen_q   <= '0;
			for (int i = 0; i < HDR_BYTES_L; i++) begin
				hdr_q[i] <= 8'd0;
			end
			fc_q     <= 8'd0;
			addr_q   <= 16'd0;
			val_q    <= 16'd0;
			code_q   <= spdu_pkg::EXC_NONE;
			nbytes_q <= 8'd0;
			ptr_q    <= '0;
			elem_q   <= '0;
			cnt_q    <= '0;
			k_q      <= '0;
			acc_q    <= 8'd0;
			byte_q   <= 8'd0;
			hi_q     <= 8'd0;
			word_q   <= 16'd0;
			ok_q     <= 1'b0;
			ph_q     <= '0;
			bptr_q   <= '0;
			lsel_q   <= '0;
			lok_q    <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == CLR_W'(MAX_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						case (action)
							spdu_pkg::ACT_REQ: begin
								if (len_q < LEN_W'(HDR_BYTES_L)) begin
									hdr_q[len_q[2:0]] <= pdu_byte;
								end
								if (len_q < LEN_W'(REQ_DEPTH)) begin
									len_q <= len_q + LEN_W'(1);
								end
								if (pdu_last) begin
									state_q <= S_CHK;
								end
							end
							spdu_pkg::ACT_READ: begin
								lsel_q  <= table_sel;
								lok_q   <= lidx_ok;
								state_q <= S_LRD;
							end
							default: ;
						endcase
					end
				end
				S_LRD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_CHK: begin
					fc_q     <= h_fc;
					addr_q   <= h_addr;
					val_q    <= h_val;
					code_q   <= code;
					nbytes_q <= is_bits ? nb_bits[7:0] : nb_words[7:0];
					cnt_q    <= is_bits ? nb_bits : val17;
					ptr_q    <= diff;
					elem_q   <= '0;
					k_q      <= '0;
					acc_q    <= 8'd0;
					ph_q     <= '0;
					bptr_q   <= spdu_pkg::BPTR_W'(HDR_BYTES_L);
					rlen_q   <= len_q;
					len_q    <= '0;
					if (code != spdu_pkg::EXC_NONE) begin
						state_q <= S_EXC;
					end else begin
						case (h_fc)
							spdu_pkg::FC_READ_COILS, spdu_pkg::FC_READ_DISCRETE,
							spdu_pkg::FC_READ_HOLDING, spdu_pkg::FC_READ_INREGS:
								state_q <= S_RHDR;
							spdu_pkg::FC_WRITE_COILS: state_q <= S_WB_ISSUE;
							spdu_pkg::FC_WRITE_REGS:  state_q <= S_WW_ISSUE;
							default:                  state_q <= S_ECHO;
						endcase
					end
				end
				S_EXC: begin
					if (out_free) begin
						ph_q <= ph_q + 3'd1;
						if (ph_q == 3'd1) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ECHO: begin
					if (out_free) begin
						ph_q <= ph_q + 3'd1;
						if (ph_q == 3'd4) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RHDR: begin
					if (out_free) begin
						ph_q <= ph_q + 3'd1;
						if (ph_q == 3'd1) begin
							state_q <= ((fc_q == spdu_pkg::FC_READ_COILS) ||
							            (fc_q == spdu_pkg::FC_READ_DISCRETE)) ?
							           S_RB_ISSUE : S_RW_ISSUE;
						end
					end
				end
				// bit reads: one entry per issue and take step, packed lsb first
				S_RB_ISSUE: state_q <= S_RB_TAKE;
				S_RB_TAKE: begin
					acc_q[k_q] <= (elem_q < {1'b0, val_q}) &&
					              ((fc_q == spdu_pkg::FC_READ_COILS) ? coil_rd : disc_rd);
					ptr_q  <= ptr_q + 17'd1;
					elem_q <= elem_q + 17'd1;
					k_q    <= k_q + 3'd1;
					state_q <= (k_q == 3'd7) ? S_RB_EMIT : S_RB_ISSUE;
				end
				S_RB_EMIT: begin
					if (out_free) begin
						cnt_q <= cnt_q - 17'd1;
						acc_q <= 8'd0;
						state_q <= (cnt_q == 17'd1) ? S_IDLE : S_RB_ISSUE;
					end
				end
				// register reads: high byte then low byte
				S_RW_ISSUE: state_q <= S_RW_TAKE;
				S_RW_TAKE: begin
					word_q  <= (fc_q == spdu_pkg::FC_READ_HOLDING) ? hold_rd : inreg_rd;
					ptr_q   <= ptr_q + 17'd1;
					state_q <= S_RW_HI;
				end
				S_RW_HI: begin
					if (out_free) begin
						state_q <= S_RW_LO;
					end
				end
				S_RW_LO: begin
					if (out_free) begin
						cnt_q <= cnt_q - 17'd1;
						state_q <= (cnt_q == 17'd1) ? S_IDLE : S_RW_ISSUE;
					end
				end
				// multiple coil write: one request byte feeds up to eight coils
				S_WB_ISSUE: begin
					ok_q    <= buf_data_ok;
					bptr_q  <= bptr_q + spdu_pkg::BPTR_W'(1);
					state_q <= S_WB_TAKE;
				end
				S_WB_TAKE: begin
					byte_q  <= buf_byte;
					k_q     <= '0;
					state_q <= S_WB_BIT;
				end
				S_WB_BIT: begin
					ptr_q  <= ptr_q + 17'd1;
					elem_q <= elem_q + 17'd1;
					k_q    <= k_q + 3'd1;
					if (elem_q + 17'd1 == {1'b0, val_q}) begin
						state_q <= S_ECHO;
					end else if (k_q == 3'd7) begin
						state_q <= S_WB_ISSUE;
					end
				end
				// multiple register write: two request bytes per register
				S_WW_ISSUE: begin
					ok_q    <= buf_data_ok;
					bptr_q  <= bptr_q + spdu_pkg::BPTR_W'(1);
					state_q <= S_WW_HI;
				end
				S_WW_HI: begin
					hi_q    <= buf_byte;
					ok_q    <= buf_data_ok;
					bptr_q  <= bptr_q + spdu_pkg::BPTR_W'(1);
					state_q <= S_WW_LO;
				end
				S_WW_LO: begin
					ptr_q  <= ptr_q + 17'd1;
					elem_q <= elem_q + 17'd1;
					state_q <= (elem_q + 17'd1 == {1'b0, val_q}) ? S_ECHO : S_WW_ISSUE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// memories
	spdu_ram #(.WIDTH(8), .DEPTH(REQ_DEPTH)) u_req_ram (
		.clk   (clk),
		.we    (buf_we),
		.waddr (len_q[RAW-1:0]),
		.wdata (pdu_byte),
		.re    (buf_re),
		.raddr (bptr_q[RAW-1:0]),
		.rdata (buf_rd)
	);

	spdu_ram #(.WIDTH(1), .DEPTH(COIL_DEPTH)) u_coil_ram (
		.clk   (clk),
		.we    (coil_we),
		.waddr (coil_wa),
		.wdata (coil_wd),
		.re    (tbl_re),
		.raddr ((state_q == S_IDLE) ? CAW'(lidx) : CAW'(ptr_q)),
		.rdata (coil_rd)
	);

	spdu_ram #(.WIDTH(1), .DEPTH(DISCRETE_DEPTH)) u_disc_ram (
		.clk   (clk),
		.we    (disc_we),
		.waddr (disc_wa),
		.wdata (disc_wd),
		.re    (tbl_re),
		.raddr ((state_q == S_IDLE) ? DAW'(lidx) : DAW'(ptr_q)),
		.rdata (disc_rd)
	);

	spdu_ram #(.WIDTH(16), .DEPTH(HOLDING_DEPTH)) u_hold_ram (
		.clk   (clk),
		.we    (hold_we),
		.waddr (hold_wa),
		.wdata (hold_wd),
		.re    (tbl_re),
		.raddr ((state_q == S_IDLE) ? HAW'(lidx) : HAW'(ptr_q)),
		.rdata (hold_rd)
	);

	spdu_ram #(.WIDTH(16), .DEPTH(INREG_DEPTH)) u_inreg_ram (
		.clk   (clk),
		.we    (inreg_we),
		.waddr (inreg_wa),
		.wdata (inreg_wd),
		.re    (tbl_re),
		.raddr ((state_q == S_IDLE) ? IAW'(lidx) : IAW'(ptr_q)),
		.rdata (inreg_rd)
	);

	// checks
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free) else $error("result loaded into a full output stage");

	a_last_serves: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (action == spdu_pkg::ACT_REQ) && pdu_last) |=> (state_q == S_CHK))
		else $error("final request byte did not start the check");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(REQ_DEPTH)) else $error("request length beyond buffer");

	a_buf_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(buf_we && buf_re)) else $error("request buffer written while serving");

endmodule
`default_nettype wire

// ----- rtl/slave_pdu_register_map_engine.sv -----
// Modbus slave pdu engine: config registers, output stage and sequencer.
// After reset a clearing pass over max(table depths) entries (1024 by default)
// zeroes the tables; no item is taken meanwhile, config writes are.
// Request bytes and local writes are taken while idle; a local read's result
// passes through the read state and the output register. A served request is
// checked, then header/echo bytes go out; each coil/discrete data byte packs
// eight 1-bit table reads and each register read is sent high byte first.
`default_nettype none
module slave_pdu_register_map_engine #(
	parameter int COIL_DEPTH     = spdu_pkg::COIL_DEPTH_DEF,
	parameter int DISCRETE_DEPTH = spdu_pkg::DISCRETE_DEPTH_DEF,
	parameter int HOLDING_DEPTH  = spdu_pkg::HOLDING_DEPTH_DEF,
	parameter int INREG_DEPTH    = spdu_pkg::INREG_DEPTH_DEF,
	parameter int REQ_DEPTH      = spdu_pkg::REQ_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [spdu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [spdu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    action,
	input  wire logic [7:0]                    pdu_byte,
	input  wire logic                          pdu_last,
	input  wire logic [1:0]                    table_sel,
	input  wire logic [9:0]                    local_index,
	input  wire logic [15:0]                   local_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               out_kind,
	output logic [7:0]                         resp_byte,
	output logic                               resp_last,
	output logic [15:0]                        read_value
);

	spdu_pkg::cfg_t      cfg_q;
	spdu_pkg::out_item_t item;
	spdu_pkg::out_item_t out_q;
	logic                out_valid_q;
	logic                out_free;
	logic                out_load;
	logic                in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				spdu_pkg::CFG_COIL_BASE:      cfg_q.coil_base      <= cfg_data;
				spdu_pkg::CFG_COIL_COUNT:     cfg_q.coil_count     <= cfg_data[10:0];
				spdu_pkg::CFG_DISCRETE_BASE:  cfg_q.discrete_base  <= cfg_data;
				spdu_pkg::CFG_DISCRETE_COUNT: cfg_q.discrete_count <= cfg_data[10:0];
				spdu_pkg::CFG_HOLDING_BASE:   cfg_q.holding_base   <= cfg_data;
				spdu_pkg::CFG_HOLDING_COUNT:  cfg_q.holding_count  <= cfg_data[8:0];
				spdu_pkg::CFG_INREG_BASE:     cfg_q.inreg_base     <= cfg_data;
				spdu_pkg::CFG_INREG_COUNT:    cfg_q.inreg_count    <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_q       <= item;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_q.out_kind;
	assign resp_byte  = out_q.resp_byte;
	assign resp_last  = out_q.resp_last;
	assign read_value = out_q.read_value;
	assign in_stall   = !in_ready;

	spdu_engine #(
		.COIL_DEPTH     (COIL_DEPTH),
		.DISCRETE_DEPTH (DISCRETE_DEPTH),
		.HOLDING_DEPTH  (HOLDING_DEPTH),
		.INREG_DEPTH    (INREG_DEPTH),
		.REQ_DEPTH      (REQ_DEPTH)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.pdu_byte    (pdu_byte),
		.pdu_last    (pdu_last),
		.table_sel   (table_sel),
		.local_index (local_index),
		.local_data  (local_data),
		.cfg         (cfg_q),
		.out_free    (out_free),
		.out_load    (out_load),
		.out_item    (item)
	);

endmodule
`default_nettype wire
